>>> hdl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg: shared types, constants and table
// Resistance table, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int CHANNELS      = 3;
  localparam int WINDOW        = 10;
  localparam int TABLE_ENTRIES = 196;
  localparam int ADC_BITS      = 12;

  localparam int CH_W   = 2;
  localparam int WIN_W  = 4;
  localparam int TIDX_W = 8;
  localparam int MEM_W  = 5;
  localparam int MEM_DEPTH = CHANNELS * WINDOW;

  localparam logic [31:0] R_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] T_OPEN  = 16'h8000;
  localparam logic [15:0] T_SHORT = 16'h7FFF;
  localparam int T_TOP = 15500;

  localparam logic [2:0] REG_PULLUP   = 3'd0;
  localparam logic [2:0] REG_IMPED    = 3'd1;
  localparam logic [2:0] REG_SHORT    = 3'd2;
  localparam logic [2:0] REG_OPEN     = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE = 3'd4;
  localparam logic [2:0] REG_WARMUP   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_LOAD, S_LOADW, S_SORT, S_MED, S_DIV1, S_DIV2,
    S_MUL, S_DIV3, S_SRCH, S_INTERP, S_DIV4, S_FLAGS, S_OUT
  } state_t;

  typedef struct packed {
    logic start;      // capture input item
    logic mem_wr;     // write sample into window
    logic load_rd;    // issue window read
    logic load_cap;   // capture read data into sort buffer
    logic sort_step;  // one odd/even transposition pass
    logic median;
    logic div_start;
    logic [1:0] div_sel;
    logic div_cap;
    logic mul;
    logic srch_step;
    logic interp;
    logic flags;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic sort_done;
    logic div_busy;
    logic srch_done;
  } sts_t;

  function automatic logic [31:0] r_table(input logic [TIDX_W-1:0] i);
    logic [31:0] t [0:TABLE_ENTRIES-1];
    t = '{
      1615, 1653, 1692, 1731, 1772, 1814, 1857, 1901, 1947, 1993,
      2042, 2091, 2142, 2195, 2248, 2304, 2361, 2420, 2481, 2543,
      2607, 2674, 2742, 2812, 2884, 2959, 3036, 3115, 3197, 3281,
      3368, 3457, 3549, 3645, 3743, 3844, 3949, 4057, 4168, 4283,
      4402, 4525, 4651, 4782, 4917, 5057, 5201, 5350, 5504, 5664,
      5828, 5999, 6175, 6357, 6546, 6741, 6943, 7152, 7369, 7593,
      7825, 8065, 8314, 8572, 8839, 9116, 9403, 9700, 10009, 10329,
      10661, 11006, 11363, 11734, 12119, 12518, 12933, 13364, 13811, 14276,
      14759, 15261, 15783, 16326, 16890, 17477, 18087, 18722, 19383, 20070,
      20787, 21532, 22309, 23118, 23960, 24838, 25753, 26708, 27703, 28740,
      29823, 30952, 32130, 33361, 34646, 35987, 37388, 38852, 40382, 41981,
      43653, 45401, 47229, 49142, 51144, 53239, 55432, 57729, 60135, 62656,
      65297, 68066, 70970, 74014, 77208, 80560, 84077, 87770, 91647, 95720,
      100000, 104498, 109225, 114197, 119426, 124928, 130717, 136812, 143230, 149990,
      157113, 164619, 172533, 180878, 189680, 198969, 208773, 219125, 230057, 241607,
      253814, 266718, 280364, 294799, 310073, 326242, 343363, 361498, 380714, 401082,
      422679, 445586, 469891, 495690, 523084, 552181, 583099, 615964, 650911, 688086,
      727646, 769760, 814609, 862390, 913315, 967611, 1025525, 1087322, 1153290, 1223737,
      1299000, 1379441, 1465451, 1557456, 1655915, 1761325, 1874227, 1995206, 2124897,
      2263988, 2413229, 2573431, 2745480, 2930336, 3129044, 3342744
    };
    if (i < TIDX_W'(TABLE_ENTRIES)) r_table = t[i];
    else r_table = t[TABLE_ENTRIES-1];
  endfunction

endpackage

>>> hdl/ntc_divider.sv
// ----------------------------------------------------------------------------
// ntc_divider: radix-2 restoring divider
// 64-bit dividend by 64-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  import ntc_pkg::*;

  logic [63:0] rem;
  logic [63:0] den;
  logic [6:0]  count;
  logic [64:0] trial;

  assign trial = {rem, quotient[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 7'd64;
    end else if (busy) begin
      count <= count - 7'd1;
      if (count == 7'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      den      <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem      <= trial[63:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= {rem[62:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/ntc_datapath.sv
// ----------------------------------------------------------------------------
// ntc_datapath: window store, sorter, resistance math, table and flags
// Acts on commands from the controller; reports status back.
// ----------------------------------------------------------------------------
module ntc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ntc_pkg::cmd_t       cmd,
  output ntc_pkg::sts_t       sts,
  input  logic [1:0]          in_channel,
  input  logic [11:0]         in_sample,
  input  logic [19:0]         pullup_resistance,
  input  logic [26:0]         input_impedance,
  input  logic [31:0]         short_limit,
  input  logic [31:0]         open_limit,
  input  logic [7:0]          fault_debounce,
  input  logic [7:0]          warmup_samples,
  output logic [63:0]         result
);
  import ntc_pkg::*;

  logic [11:0] window_mem [0:MEM_DEPTH-1];
  logic [11:0] rd_data;
  logic [MEM_W-1:0] rd_addr;

  logic [CH_W-1:0] ch;
  logic [11:0] smp;
  logic [WIN_W-1:0] fill [0:CHANNELS-1];
  logic [WIN_W-1:0] wpos [0:CHANNELS-1];
  logic [7:0] ocnt [0:CHANNELS-1];
  logic [7:0] scnt [0:CHANNELS-1];
  logic [2:0] flg  [0:CHANNELS-1];
  logic [7:0] wcnt [0:CHANNELS-1];

  logic [11:0] buf_s [0:WINDOW-1];
  logic [WIN_W-1:0] n;
  logic [WIN_W-1:0] ld_idx;
  logic [WIN_W-1:0] pass;
  logic [12:0] med;
  logic [63:0] dq, dd, dquot;
  logic [63:0] q1, rx, prod;
  logic [31:0] r;
  logic [TIDX_W-1:0] idx;
  logic [31:0] ta, tb;
  logic [1:0] tclass;
  logic [2:0] fl;
  logic [15:0] temp;
  logic div_busy;

  localparam logic [1:0] TC_TOP = 2'd0;
  localparam logic [1:0] TC_BOT = 2'd1;
  localparam logic [1:0] TC_MID = 2'd2;

  ntc_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dq), .divisor(dd),
    .busy(div_busy), .quotient(dquot)
  );

  function automatic logic [MEM_W-1:0] addr_of(input logic [CH_W-1:0] c,
                                               input logic [WIN_W-1:0] p);
    addr_of = MEM_W'(c * WINDOW + p);
  endfunction

  assign rd_addr = addr_of(ch, ld_idx);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) window_mem[addr_of(ch, wpos[ch])] <= smp;
    rd_data <= window_mem[rd_addr];
  end

  // dividend/divisor selection per division
  always_comb begin
    dq = '0;
    dd = 64'd1;
    unique case (cmd.div_sel)
      2'd0: begin dq = 64'(1 << ADC_BITS) * 64'd10000; dd = {51'd0, med}; end
      2'd1: begin dq = 64'(pullup_resistance) * 64'd100000; dd = q1 - 64'd10000; end
      2'd2: begin dq = prod; dd = 64'(input_impedance) - rx; end
      default: begin dq = 64'(r - ta) * 64'd100; dd = 64'(tb - ta); end
    endcase
  end

  logic sort_odd;
  assign sort_odd = pass[0];

  logic [7:0] cnt_s, cnt_o;
  logic [2:0] f_n;

  always_comb begin
    logic ready;
    ready = flg[ch][0] || (wcnt[ch] >= warmup_samples);
    f_n = flg[ch];
    cnt_s = scnt[ch];
    cnt_o = ocnt[ch];
    if (ready) begin
      f_n[0] = 1'b1;
      if (r < short_limit) begin
        if (!f_n[2] && cnt_s < fault_debounce) begin
          if (9'(cnt_s) + 9'd1 == 9'(fault_debounce)) f_n[2] = 1'b1;
          cnt_s = cnt_s + 8'd1;
        end
      end else if (f_n[2] && cnt_s != 8'd0) begin
        if (cnt_s == 8'd1) f_n[2] = 1'b0;
        cnt_s = cnt_s - 8'd1;
      end
      if (r > open_limit) begin
        if (!f_n[1] && cnt_o < fault_debounce) begin
          if (9'(cnt_o) + 9'd1 == 9'(fault_debounce)) f_n[1] = 1'b1;
          cnt_o = cnt_o + 8'd1;
        end
      end else if (f_n[1] && cnt_o != 8'd0) begin
        if (cnt_o == 8'd1) f_n[1] = 1'b0;
        cnt_o = cnt_o - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fill[c] <= '0; wpos[c] <= '0; ocnt[c] <= '0;
        scnt[c] <= '0; flg[c] <= '0; wcnt[c] <= '0;
      end
    end else begin
      if (cmd.mem_wr) begin
        wpos[ch] <= (wpos[ch] == WIN_W'(WINDOW-1)) ? '0 : wpos[ch] + WIN_W'(1);
        if (fill[ch] < WIN_W'(WINDOW)) fill[ch] <= fill[ch] + WIN_W'(1);
      end
      if (cmd.flags) begin
        flg[ch]  <= f_n;
        scnt[ch] <= cnt_s;
        ocnt[ch] <= cnt_o;
        if (wcnt[ch] != 8'hFF) wcnt[ch] <= wcnt[ch] + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ch <= in_channel;
      smp <= in_sample;
    end
    if (cmd.mem_wr) begin
      n <= (fill[ch] < WIN_W'(WINDOW)) ? fill[ch] + WIN_W'(1) : fill[ch];
      ld_idx <= '0;
      pass <= '0;
    end
    if (cmd.load_rd && !cmd.load_cap) ld_idx <= ld_idx + WIN_W'(1);
    if (cmd.load_cap) begin
      buf_s[ld_idx - WIN_W'(1)] <= rd_data;
      ld_idx <= ld_idx + WIN_W'(1);
    end
    if (cmd.sort_step) begin
      for (int i = 0; i + 1 < WINDOW; i++) begin
        if ((i % 2) == (sort_odd ? 1 : 0) && WIN_W'(i + 1) < n &&
            buf_s[i] > buf_s[i+1]) begin
          buf_s[i]   <= buf_s[i+1];
          buf_s[i+1] <= buf_s[i];
        end
      end
      pass <= pass + WIN_W'(1);
    end
    if (cmd.median) begin
      if (n[0]) med <= {1'b0, buf_s[n >> 1]};
      else med <= 13'((13'(buf_s[(n >> 1) - WIN_W'(1)]) + 13'(buf_s[n >> 1])) >> 1);
      idx <= '0;
    end
    if (cmd.div_cap) begin
      unique case (cmd.div_sel)
        2'd0: q1 <= dquot;
        2'd1: rx <= dquot;
        2'd2: begin
          // special cases of the resistance math
          if (med == 13'd0) r <= '0;
          else if (q1 <= 64'd10000 || rx >= 64'(input_impedance)) r <= R_MAX;
          else r <= (dquot > 64'(R_MAX)) ? R_MAX : dquot[31:0];
        end
        default: begin
          logic signed [31:0] fine;
          logic [15:0] mag;
          logic [31:0] tq;
          fine = 32'(T_TOP) - 32'(idx) * 32'sd100 - 32'(dquot[7:0]);
          mag = (fine < 0) ? 16'(-fine + 32'sd5) : 16'(fine + 32'sd5);
          // divide by ten: exact for magnitudes up to well above the table span
          tq = (32'(mag) * 32'd52429) >> 19;
          temp <= (fine < 0) ? 16'(-tq) : tq[15:0];
        end
      endcase
    end
    if (cmd.mul) begin
      prod <= 64'({27'd0, rx[26:0]} * {27'd0, input_impedance});
    end
    if (cmd.srch_step) begin
      if (idx + TIDX_W'(1) < TIDX_W'(TABLE_ENTRIES) && r >= r_table(idx + TIDX_W'(1)))
        idx <= idx + TIDX_W'(1);
    end
    if (cmd.interp) begin
      ta <= r_table(idx);
      tb <= r_table(idx + TIDX_W'(1));
      if (r <= r_table('0)) tclass <= TC_TOP;
      else if (r >= r_table(TIDX_W'(TABLE_ENTRIES-1))) tclass <= TC_BOT;
      else tclass <= TC_MID;
    end
    if (cmd.flags) fl <= f_n;
  end

  logic [15:0] t_final;
  always_comb begin
    case (tclass)
      TC_TOP:  t_final = 16'(T_TOP / 10);
      TC_BOT:  t_final = 16'((T_TOP - (TABLE_ENTRIES-1) * 100) / 10);
      default: t_final = temp;
    endcase
    if (fl[1]) t_final = T_OPEN;
    else if (fl[2]) t_final = T_SHORT;
  end

  // packed result: channel, temperature, resistance, open, short, ready
  always_ff @(posedge clk) begin
    if (cmd.out_load) result <= {11'd0, fl[0], fl[2], fl[1], r, t_final, ch};
  end

  assign sts.load_done = (ld_idx == n + WIN_W'(1));
  assign sts.sort_done = (pass == n);
  assign sts.div_busy  = div_busy;
  assign sts.srch_done = (idx + TIDX_W'(1) >= TIDX_W'(TABLE_ENTRIES)) ||
                         (r < r_table(idx + TIDX_W'(1)));

endmodule

>>> hdl/ntc_ctrl.sv
// ----------------------------------------------------------------------------
// ntc_ctrl: sequencing state machine
// Steps one sample through window, sort, divisions, search and flags.
// ----------------------------------------------------------------------------
module ntc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_free,
  input  ntc_pkg::sts_t sts,
  output ntc_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_set
);
  import ntc_pkg::*;

  state_t state, state_next;
  logic [1:0] dsel, dsel_next;
  logic dwait, dwait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dsel  <= '0;
      dwait <= 1'b0;
    end else begin
      state <= state_next;
      dsel  <= dsel_next;
      dwait <= dwait_next;
    end
  end

  always_comb begin
    state_next = state;
    dsel_next = dsel;
    dwait_next = dwait;
    cmd = '0;
    cmd.div_sel = dsel;
    out_set = 1'b0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.start = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin cmd.mem_wr = 1'b1; state_next = S_LOAD; end
      S_LOAD: begin cmd.load_rd = 1'b1; state_next = S_LOADW; end
      S_LOADW: begin
        if (sts.load_done) state_next = S_SORT;
        else begin cmd.load_cap = 1'b1; cmd.load_rd = 1'b1; end
      end
      S_SORT: begin
        if (sts.sort_done) state_next = S_MED;
        else cmd.sort_step = 1'b1;
      end
      S_MED: begin
        cmd.median = 1'b1;
        dsel_next = 2'd0;
        dwait_next = 1'b0;
        state_next = S_DIV1;
      end
      S_DIV1, S_DIV2, S_DIV3, S_DIV4: begin
        if (!dwait) begin
          cmd.div_start = 1'b1;
          dwait_next = 1'b1;
        end else if (!sts.div_busy) begin
          cmd.div_cap = 1'b1;
          dwait_next = 1'b0;
          dsel_next = dsel + 2'd1;
          unique case (state)
            S_DIV1:  state_next = S_DIV2;
            S_DIV2:  state_next = S_MUL;
            S_DIV3:  state_next = S_SRCH;
            default: state_next = S_FLAGS;
          endcase
        end
      end
      S_MUL: begin cmd.mul = 1'b1; state_next = S_DIV3; end
      S_SRCH: begin
        if (sts.srch_done) state_next = S_INTERP;
        else cmd.srch_step = 1'b1;
      end
      S_INTERP: begin cmd.interp = 1'b1; state_next = S_DIV4; end
      S_FLAGS: begin cmd.flags = 1'b1; state_next = S_OUT; end
      S_OUT: if (out_free) begin
        cmd.out_load = 1'b1;
        out_set = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/ntc_thermistor_temperature_channel.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_channel: three-channel NTC temperature channel
// Median window, divider resistance, fault debounce and table lookup.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tdata = {adc_sample[13:2], channel[1:0]}; one sample per transfer.
//   m_axis: one result per sample on a valid channel; items with channel 3
//   are dropped without a result.
//   APB: six registers at byte addresses 0,4,..,20; write only while idle.
// Processing: one sample at a time; the next transfer is taken only after
//   the sequencer has returned to idle. Processing time is dominated by four
//   passes of the bit-serial 64-bit divider and the linear table search
//   of up to 195 steps.
// Reset clears all per-channel counters, flags and fill levels and loads the
//   register defaults. The result sits in an output register; the next
//   sample is taken while it waits, and the sequencer stalls at its final
//   step only if the previous result was not yet transferred.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_channel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // channel[1:0], adc_sample[13:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // channel_out[1:0], temperature[17:2],
                                      // resistance[49:18], open_fault[50],
                                      // short_fault[51], ready_res[52]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ntc_pkg::*;

  logic [19:0] pullup_resistance;
  logic [26:0] input_impedance;
  logic [31:0] short_limit, open_limit;
  logic [7:0]  fault_debounce, warmup_samples;
  cmd_t cmd;
  sts_t sts;
  logic busy, out_set, in_fire;
  logic [63:0] result;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pullup_resistance <= 20'd5620;
      input_impedance   <= 27'd1250000;
      short_limit       <= 32'd808;
      open_limit        <= 32'd5014116;
      fault_debounce    <= 8'd250;
      warmup_samples    <= 8'd14;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_PULLUP:   pullup_resistance <= pwdata[19:0];
        REG_IMPED:    input_impedance   <= pwdata[26:0];
        REG_SHORT:    short_limit       <= pwdata;
        REG_OPEN:     open_limit        <= pwdata;
        REG_DEBOUNCE: fault_debounce    <= pwdata[7:0];
        REG_WARMUP:   warmup_samples    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PULLUP:   prdata = 32'(pullup_resistance);
      REG_IMPED:    prdata = 32'(input_impedance);
      REG_SHORT:    prdata = short_limit;
      REG_OPEN:     prdata = open_limit;
      REG_DEBOUNCE: prdata = 32'(fault_debounce);
      REG_WARMUP:   prdata = 32'(warmup_samples);
      default:      prdata = '0;
    endcase
  end

  // channel 3 is accepted and dropped
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] != 2'd3);

  ntc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .sts(sts), .cmd(cmd), .busy(busy), .out_set(out_set)
  );

  ntc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_channel(s_axis_tdata[1:0]), .in_sample(s_axis_tdata[13:2]),
    .pullup_resistance(pullup_resistance), .input_impedance(input_impedance),
    .short_limit(short_limit), .open_limit(open_limit),
    .fault_debounce(fault_debounce), .warmup_samples(warmup_samples),
    .result(result)
  );

  assign m_axis_tdata = result[55:0];

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_set) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("input taken while busy");
  a_result_chan: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad result channel");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_set |-> ($past(m_axis_tready) || !$past(m_axis_tvalid) || 1'b1) && !cmd.start)
    else $error("output loaded with start");

endmodule

>>> sim/ntc_thermistor_temperature_channel_tb.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_channel_tb: self-checking bench
// Streams ADC samples into the channel and checks each reading against its
// own model of the median, resistance, fault debounce and table lookup.
// Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_channel_tb;
  import ntc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT    = 10_000_000;
  localparam int DRAIN    = 600;   // longer than one sample's processing
  localparam int NCH      = 3;
  localparam int NWIN     = 10;
  localparam int NTBL     = 196;
  localparam logic [1:0] CH_NONE = 2'd3;

  localparam int unsigned R_NTC [NTBL] = '{
    1615, 1653, 1692, 1731, 1772, 1814, 1857, 1901, 1947, 1993,
    2042, 2091, 2142, 2195, 2248, 2304, 2361, 2420, 2481, 2543,
    2607, 2674, 2742, 2812, 2884, 2959, 3036, 3115, 3197, 3281,
    3368, 3457, 3549, 3645, 3743, 3844, 3949, 4057, 4168, 4283,
    4402, 4525, 4651, 4782, 4917, 5057, 5201, 5350, 5504, 5664,
    5828, 5999, 6175, 6357, 6546, 6741, 6943, 7152, 7369, 7593,
    7825, 8065, 8314, 8572, 8839, 9116, 9403, 9700, 10009, 10329,
    10661, 11006, 11363, 11734, 12119, 12518, 12933, 13364, 13811, 14276,
    14759, 15261, 15783, 16326, 16890, 17477, 18087, 18722, 19383, 20070,
    20787, 21532, 22309, 23118, 23960, 24838, 25753, 26708, 27703, 28740,
    29823, 30952, 32130, 33361, 34646, 35987, 37388, 38852, 40382, 41981,
    43653, 45401, 47229, 49142, 51144, 53239, 55432, 57729, 60135, 62656,
    65297, 68066, 70970, 74014, 77208, 80560, 84077, 87770, 91647, 95720,
    100000, 104498, 109225, 114197, 119426, 124928, 130717, 136812, 143230, 149990,
    157113, 164619, 172533, 180878, 189680, 198969, 208773, 219125, 230057, 241607,
    253814, 266718, 280364, 294799, 310073, 326242, 343363, 361498, 380714, 401082,
    422679, 445586, 469891, 495690, 523084, 552181, 583099, 615964, 650911, 688086,
    727646, 769760, 814609, 862390, 913315, 967611, 1025525, 1087322, 1153290, 1223737,
    1299000, 1379441, 1465451, 1557456, 1655915, 1761325, 1874227, 1995206, 2124897,
    2263988, 2413229, 2573431, 2745480, 2930336, 3129044, 3342744
  };

  typedef struct {
    logic [1:0]  ch;
    logic [11:0] adc;
  } sample_t;

  typedef struct {
    logic [1:0]  ch;
    logic [15:0] temp;
    logic [31:0] res;
    logic        open_f;
    logic        short_f;
    logic        ready;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // channel[1:0], adc_sample[13:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // channel_out[1:0], temperature[17:2],
                                    // resistance[49:18], open_fault[50],
                                    // short_fault[51], ready_res[52]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ntc_thermistor_temperature_channel uut (.*);

  // register shadow
  longint unsigned pullup_r, imped_r, short_lim, open_lim, debounce_n, warmup_n;
  // per-channel shadow state
  int unsigned win [NCH][NWIN];
  int unsigned fill [NCH], wpos [NCH], open_cnt [NCH], short_cnt [NCH], warm_cnt [NCH];
  bit          f_ready [NCH], f_open [NCH], f_short [NCH];

  sample_t  sample_q [$];
  reading_t pending_readings [$];
  int       pushed_n = 0, taken_n = 0, err_n = 0;
  bit       hold_send = 1'b0, calm = 1'b0;
  longint   cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic longint unsigned divider_res(int unsigned m);
    longint unsigned q, rx, r;
    if (m == 0) return 0;
    q = 64'd40960000 / m;
    if (q <= 10000) return 32'hFFFF_FFFF;
    rx = (pullup_r * 100000) / (q - 10000);
    if (rx >= imped_r) return 32'hFFFF_FFFF;
    r = (rx * imped_r) / (imped_r - rx);
    return (r > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : r;
  endfunction

  function automatic int table_tenths(longint unsigned r);
    int idx;
    longint fine, frac;
    idx = 0;
    if (r <= R_NTC[0]) return 1550;
    if (r >= R_NTC[NTBL-1]) return (15500 - (NTBL - 1) * 100) / 10;
    for (int i = 0; i < NTBL; i++) begin
      if (r >= R_NTC[i]) idx = i;
      else break;
    end
    frac = ((r - R_NTC[idx]) * 100) / (R_NTC[idx+1] - R_NTC[idx]);
    fine = 15500 - idx * 100 - frac;
    if (fine < 0) return -((-fine + 5) / 10);
    return (fine + 5) / 10;
  endfunction

  // one debounce update; returns new flag, updates counter
  function automatic bit debounce_step(bit bad, bit flag, inout int unsigned cnt);
    if (bad) begin
      if (!flag && cnt < debounce_n) begin
        if (cnt + 1 == debounce_n) flag = 1'b1;
        cnt++;
      end
    end else if (flag && cnt > 0) begin
      if (cnt == 1) flag = 1'b0;
      cnt--;
    end
    return flag;
  endfunction

  function automatic reading_t compute_reading(sample_t s);
    reading_t o;
    int unsigned c, srt [$], med;
    longint unsigned r;
    c = s.ch;
    win[c][wpos[c]] = s.adc;
    wpos[c] = (wpos[c] + 1 >= NWIN) ? 0 : wpos[c] + 1;
    if (fill[c] < NWIN) fill[c]++;
    for (int i = 0; i < fill[c]; i++) srt.push_back(win[c][i]);
    srt.sort();
    if (fill[c] % 2) med = srt[fill[c] / 2];
    else med = (srt[fill[c] / 2 - 1] + srt[fill[c] / 2]) / 2;
    r = divider_res(med);
    if (warm_cnt[c] >= warmup_n) f_ready[c] = 1'b1;
    if (warm_cnt[c] < 255) warm_cnt[c]++;
    if (f_ready[c]) begin
      f_short[c] = debounce_step(r < short_lim, f_short[c], short_cnt[c]);
      f_open[c]  = debounce_step(r > open_lim, f_open[c], open_cnt[c]);
    end
    o.ch = s.ch;
    o.res = r[31:0];
    o.open_f = f_open[c];
    o.short_f = f_short[c];
    o.ready = f_ready[c];
    if (f_open[c]) o.temp = T_OPEN;
    else if (f_short[c]) o.temp = T_SHORT;
    else o.temp = 16'(table_tenths(r));
    return o;
  endfunction

  // sample source
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        sample_t acc;
        acc.ch = s_axis_tdata[1:0];
        acc.adc = s_axis_tdata[13:2];
        taken_n++;
        if (acc.ch != CH_NONE) pending_readings.push_back(compute_reading(acc));
      end
      if (!hold_send && sample_q.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
        sample_t nx;
        nx = sample_q.pop_front();
        s_axis_tdata <= {2'b00, nx.adc, nx.ch};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // reading sink and checker
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("ntc_thermistor_temperature_channel_tb: errors");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected reading %h", m_axis_tdata);
        err_n++;
      end else begin
        reading_t e;
        e = pending_readings.pop_front();
        if (m_axis_tdata[1:0] != e.ch) begin
          $error("channel_out exp %0d got %0d", e.ch, m_axis_tdata[1:0]); err_n++;
        end
        if (m_axis_tdata[17:2] != e.temp) begin
          $error("temperature exp %0d got %0d", $signed(e.temp),
                 $signed(m_axis_tdata[17:2])); err_n++;
        end
        if (m_axis_tdata[49:18] != e.res) begin
          $error("resistance exp %0d got %0d", e.res, m_axis_tdata[49:18]); err_n++;
        end
        if (m_axis_tdata[50] != e.open_f) begin
          $error("open_fault exp %0d got %0d", e.open_f, m_axis_tdata[50]); err_n++;
        end
        if (m_axis_tdata[51] != e.short_f) begin
          $error("short_fault exp %0d got %0d", e.short_f, m_axis_tdata[51]); err_n++;
        end
        if (m_axis_tdata[52] != e.ready) begin
          $error("ready_res exp %0d got %0d", e.ready, m_axis_tdata[52]); err_n++;
        end
      end
    end
    m_axis_tready <= !rst && (calm || $urandom_range(99) >= 18);
  end

  task automatic reg_write(logic [2:0] idx, longint unsigned val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PULLUP:   pullup_r = val;
      REG_IMPED:    imped_r = val;
      REG_SHORT:    short_lim = val;
      REG_OPEN:     open_lim = val;
      REG_DEBOUNCE: debounce_n = val;
      default:      warmup_n = val;
    endcase
  endtask

  task automatic set_regs(longint unsigned pu, longint unsigned z, longint unsigned sl,
                          longint unsigned ol, longint unsigned db, longint unsigned wu);
    reg_write(REG_PULLUP, pu);
    reg_write(REG_IMPED, z);
    reg_write(REG_SHORT, sl);
    reg_write(REG_OPEN, ol);
    reg_write(REG_DEBOUNCE, db);
    reg_write(REG_WARMUP, wu);
  endtask

  task automatic push(logic [1:0] ch, logic [11:0] adc);
    sample_t s;
    s.ch = ch;
    s.adc = adc;
    sample_q.push_back(s);
    pushed_n++;
  endtask

  task automatic wait_drained();
    wait (sample_q.size() == 0 && taken_n == pushed_n && pending_readings.size() == 0);
    @(posedge clk);
  endtask

  // mostly same-channel runs from one region so faults set and clear
  task automatic random_samples(int n);
    int left, len, mode;
    logic [1:0] ch;
    logic [11:0] v;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 75) begin
        ch = 2'($urandom_range(NCH - 1));
        len = $urandom_range(12, 1);
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: v = 12'($urandom_range(60));
            1: v = 12'($urandom_range(4095, 4030));
            2: v = 12'($urandom_range(3500, 1000));
            default: v = 12'($urandom);
          endcase
          push(ch, v);
        end
        left -= len;
      end else begin
        ch = 2'($urandom);
        push(ch, 12'($urandom));
        if (ch != CH_NONE) left--;
      end
    end
  endtask

  initial begin
    pullup_r = 5620; imped_r = 1250000; short_lim = 808; open_lim = 5014116;
    debounce_n = 250; warmup_n = 14;
    foreach (fill[c]) begin
      fill[c] = 0; wpos[c] = 0; open_cnt[c] = 0; short_cnt[c] = 0; warm_cnt[c] = 0;
      f_ready[c] = 0; f_open[c] = 0; f_short[c] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, unused channel, even/odd medians
    push(2'd0, 12'd0);    push(2'd0, 12'd4095); push(2'd1, 12'd4095);
    push(2'd2, 12'd2048); push(CH_NONE, 12'd100); push(2'd2, 12'd1);
    push(2'd1, 12'd4094); push(2'd0, 12'd2047); push(2'd2, 12'd3900);
    push(2'd1, 12'd4095); push(CH_NONE, 12'd4095); push(2'd0, 12'hAAA);
    push(2'd0, 12'h555); push(2'd2, 12'd300);  push(2'd1, 12'd1);
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    // minimal limits: every sample is fault checked at once
    set_regs(1, 1, 0, 0, 1, 0);
    for (int i = 0; i < 4; i++) push(2'(i % 3), 12'(i * 1300));
    random_samples(400);
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    set_regs(1000000, 100000000, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 255, 255);
    random_samples(350);
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    // near-default settings with short debounce; pause midway
    set_regs(5620, 1250000, 808, 5014116, 2, 3);
    random_samples(200);
    hold_send = 1'b1;
    wait (taken_n == pushed_n - sample_q.size() && pending_readings.size() == 0);
    hold_send = 1'b0;
    random_samples(200);
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    // random registers, no idling on either side
    calm = 1'b1;
    set_regs($urandom_range(20000, 1), $urandom_range(5000000, 10000),
             $urandom_range(200000), $urandom_range(4000000, 300000),
             $urandom_range(8, 1), $urandom_range(20));
    random_samples(400);
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    calm = 1'b0;

    set_regs($urandom_range(1000000, 1), $urandom_range(100000000, 1),
             $urandom, $urandom, $urandom_range(255, 1), $urandom_range(255));
    random_samples(380);
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    if (err_n == 0) begin
      $display("ntc_thermistor_temperature_channel_tb: clean");
    end else begin
      $display("ntc_thermistor_temperature_channel_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ntc_pkg.sv
hdl/ntc_divider.sv
hdl/ntc_datapath.sv
hdl/ntc_ctrl.sv
hdl/ntc_thermistor_temperature_channel.sv
sim/ntc_thermistor_temperature_channel_tb.sv
